FILE: src/aes256_cbc_cipher_assert.svh
// Assertion macros used by the checker of the AES-256 CBC block.
// No dependencies.
`ifndef AES256_CBC_CIPHER_ASSERT_SVH
`define AES256_CBC_CIPHER_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define ACC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ACC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: src/acc_pkg.sv
// Shared types, constants and functions of the AES-256 CBC block.
// No dependencies.
package acc_pkg;
  localparam int unsigned NumRounds  = 14;
  localparam int unsigned SchedWords = (NumRounds + 1) * 4;
  localparam int unsigned RkAw       = $clog2(SchedWords);
  localparam int unsigned RowAw      = $clog2(NumRounds + 1);
  localparam int unsigned CfgIdxW    = 3;

  localparam logic [CfgIdxW-1:0] CFG_KEY0 = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY1 = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEY2 = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_KEY3 = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_IVH  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_IVL  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_MODE = 3'd6;

  localparam logic [7:0] GfPoly = 8'h1b;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
    endcase
    return r;
  endfunction

  // The inverse box searches the forward table; synthesis folds this constant
  // mapping into a 256-entry table.
  function automatic logic [7:0] rsbox(input logic [7:0] a);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 256; i++) begin
      if (sbox(8'(i)) == a) r = 8'(i);
    end
    return r;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GfPoly : 8'h00);
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // State is 128 bits, byte 0 in bits 127:120; byte 4c+r is row r, column c.
  function automatic logic [7:0] sb(input logic [127:0] s, input int unsigned i);
    return s[127-8*i -: 8];
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic do_mix);
    logic [127:0] t;
    logic [127:0] m;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = sbox(sb(s, 4*((c+r)%4)+r));
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = sb(t, 4*c); a1 = sb(t, 4*c+1); a2 = sb(t, 4*c+2); a3 = sb(t, 4*c+3);
      m[127-32*c -: 8]      = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      m[127-32*c-8 -: 8]    = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      m[127-32*c-16 -: 8]   = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      m[127-32*c-24 -: 8]   = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    return do_mix ? m : t;
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] a2, a4, a8;
    a2 = xt(a); a4 = xt(a2); a8 = xt(a4);
    return (b[0] ? a : 8'h00) ^ (b[1] ? a2 : 8'h00) ^ (b[2] ? a4 : 8'h00) ^
           (b[3] ? a8 : 8'h00);
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] m;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = sb(s, 4*c); a1 = sb(s, 4*c+1); a2 = sb(s, 4*c+2); a3 = sb(s, 4*c+3);
      m[127-32*c -: 8]    = gmul(a0,4'd14) ^ gmul(a1,4'd11) ^ gmul(a2,4'd13) ^ gmul(a3,4'd9);
      m[127-32*c-8 -: 8]  = gmul(a0,4'd9) ^ gmul(a1,4'd14) ^ gmul(a2,4'd11) ^ gmul(a3,4'd13);
      m[127-32*c-16 -: 8] = gmul(a0,4'd13) ^ gmul(a1,4'd9) ^ gmul(a2,4'd14) ^ gmul(a3,4'd11);
      m[127-32*c-24 -: 8] = gmul(a0,4'd11) ^ gmul(a1,4'd13) ^ gmul(a2,4'd9) ^ gmul(a3,4'd14);
    end
    return m;
  endfunction

  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*((c+r)%4)+r) -: 8] = rsbox(sb(s, 4*c+r));
      end
    end
    return t;
  endfunction

  // Status from the key scheduler to the cipher core.
  typedef struct packed {
    logic busy;
  } ks_status_t;
endpackage

FILE: src/acc_key_sched.sv
// Key expansion engine and round-key memory of the AES-256 CBC block.
// Depends on acc_pkg.
module acc_key_sched import acc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [255:0]      key_i,
  input  logic [RowAw-1:0]  rd_addr_i,
  output logic [127:0]      rd_row_o,
  output ks_status_t        status_o
);
  // One 128-bit row per round; the expansion writes one word a cycle.
  logic [127:0] mem_q [NumRounds+1];
  logic [127:0] rd_q;

  logic             run_q, run_d;
  logic [RkAw-1:0]  idx_q, idx_d;
  logic [7:0]       rc_q, rc_d;
  // Last eight words of the schedule, oldest in slot 0.
  logic [31:0]      win_q [8];
  logic [31:0]      win_d [8];
  logic [31:0]      t, nw;

  always_comb begin
    t = win_q[7];
    rc_d = rc_q;
    if (idx_q[2:0] == 3'd0) begin
      t = sbox_word({t[23:0], t[31:24]}) ^ {rc_q, 24'h0};
      rc_d = xt(rc_q);
    end else if (idx_q[2:0] == 3'd4) begin
      t = sbox_word(t);
    end
    nw = win_q[0] ^ t;
    for (int i = 0; i < 7; i++) win_d[i] = win_q[i+1];
    win_d[7] = nw;
    idx_d = idx_q + RkAw'(1);
    run_d = (idx_q != RkAw'(SchedWords - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b1;
      idx_q <= RkAw'(8);
      rc_q  <= 8'h01;
    end else if (start_i) begin
      run_q <= 1'b1;
      idx_q <= RkAw'(8);
      rc_q  <= 8'h01;
    end else if (run_q) begin
      run_q <= run_d;
      idx_q <= idx_d;
      rc_q  <= rc_d;
    end
  end

  // start_i is high in the first cycle after reset, so the all-zero key loads then.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int i = 0; i < 8; i++) win_q[i] <= key_i[255-32*i -: 32];
      mem_q[0] <= key_i[255:128];
      mem_q[1] <= key_i[127:0];
    end else if (run_q) begin
      for (int i = 0; i < 8; i++) win_q[i] <= win_d[i];
      mem_q[idx_q[RkAw-1:2]][127-32*idx_q[1:0] -: 32] <= nw;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_row_o = rd_q;
  assign status_o.busy = run_q || start_i;
endmodule

FILE: src/acc_core.sv
// Round engine of the AES-256 CBC block: one round per cycle with chaining.
// Depends on acc_pkg; reads round keys from acc_key_sched.
module acc_core import acc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ks_status_t        ks_i,
  input  logic [127:0]      rk_i,
  output logic [RowAw-1:0]  rk_addr_o,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [127:0]      in_block_i,
  input  logic              in_last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [127:0]      out_block_o,
  input  logic [127:0]      iv_i,
  input  logic [1:0]        iv_load_i,
  input  logic              decrypt_i
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;
  localparam int unsigned CntW = $clog2(NumRounds + 2);

  logic [1:0]     st_q, st_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [127:0]   s_q, s_d, chain_q, cin_q, res_q;
  logic           dec_q, last_q, ov_q;
  logic           accept, take;
  logic [127:0]   ns;

  assign in_ready_o = (st_q == ST_IDLE) && !ks_i.busy && !(ov_q && !out_ready_i);
  assign accept = in_valid_i && in_ready_o;
  assign take = ov_q && out_ready_i;

  // The round key address is issued in the cycle before the round that uses it, as the key memory read is registered.
  always_comb begin
    if (accept) rk_addr_o = decrypt_i ? RowAw'(NumRounds) : RowAw'(0);
    else if (dec_q) rk_addr_o = RowAw'(NumRounds) - RowAw'(cnt_q) - RowAw'(1);
    else rk_addr_o = RowAw'(cnt_q) + RowAw'(1);
  end

  // cnt_q counts completed key additions; round number is cnt_q.
  always_comb begin
    ns = s_q;
    if (cnt_q == CntW'(0)) ns = s_q ^ rk_i;
    else if (!dec_q) ns = enc_round(s_q, cnt_q != CntW'(NumRounds)) ^ rk_i;
    else if (cnt_q == CntW'(NumRounds)) ns = inv_shift_sub(s_q) ^ rk_i;
    else ns = inv_mix(inv_shift_sub(s_q) ^ rk_i);
    st_d = st_q;
    cnt_d = cnt_q;
    s_d = s_q;
    unique case (st_q)
      ST_IDLE: if (accept) begin
        st_d = ST_RUN;
        cnt_d = '0;
        s_d = decrypt_i ? in_block_i : in_block_i ^ chain_q;
      end
      ST_RUN: begin
        s_d = ns;
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(NumRounds)) st_d = ST_OUT;
      end
      ST_OUT: if (!ov_q || out_ready_i) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      cnt_q <= '0;
      ov_q <= 1'b0;
      chain_q <= '0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
      if (st_q == ST_OUT && (!ov_q || out_ready_i)) ov_q <= 1'b1;
      else if (take) ov_q <= 1'b0;
      if (st_q == ST_OUT && (!ov_q || out_ready_i)) begin
        chain_q <= last_q ? iv_i : (dec_q ? cin_q : s_q);
      end else begin
        if (iv_load_i[1]) chain_q[127:64] <= iv_i[127:64];
        if (iv_load_i[0]) chain_q[63:0] <= iv_i[63:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
    if (accept) begin
      cin_q <= in_block_i;
      dec_q <= decrypt_i;
      last_q <= in_last_i;
    end
    if (st_q == ST_OUT && (!ov_q || out_ready_i)) res_q <= dec_q ? s_q ^ chain_q : s_q;
  end

  assign out_valid_o = ov_q;
  assign out_block_o = res_q;
endmodule

FILE: src/aes256_cbc_cipher.sv
// Channel  | dir | payload
// s_axis   | in  | tdata {block_low, block_high}, tuser last_block
// m_axis   | out | tdata {result_low, result_high}
// cfg      | in  | index 0..6, 64-bit data
// A result is offered after its block's transfer has passed the key addition and
// the 14 rounds of the single round unit, then the hand-off state; a new block is
// taken only when the previous one has been handed off. Key expansion loads the
// key and computes the 52 remaining words right after reset and after a key write;
// no block is taken meanwhile. A stalled result holds the next block at the input.
// Top level of the AES-256 CBC block; depends on acc_pkg, acc_key_sched, acc_core.
module aes256_cbc_cipher import acc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [127:0]        s_axis_tdata,  // block_low, block_high
  input  logic                s_axis_tuser,  // last_block
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [127:0]        m_axis_tdata,  // result_low, result_high
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [63:0]         cfg_wdata_i
);
  logic [255:0] key_q;
  logic [127:0] iv_q;
  logic         dec_q;
  logic         key_wr;
  logic [1:0]   iv_ld;
  logic [127:0] rk;
  logic [RowAw-1:0] rk_addr;
  logic [127:0] res;
  ks_status_t   ks;

  assign key_wr = cfg_we_i && (cfg_idx_i == CFG_KEY0 || cfg_idx_i == CFG_KEY1 ||
                  cfg_idx_i == CFG_KEY2 || cfg_idx_i == CFG_KEY3);
  assign iv_ld = {cfg_we_i && cfg_idx_i == CFG_IVH, cfg_we_i && cfg_idx_i == CFG_IVL};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0; iv_q <= '0; dec_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEY0: key_q[255:192] <= cfg_wdata_i;
        CFG_KEY1: key_q[191:128] <= cfg_wdata_i;
        CFG_KEY2: key_q[127:64]  <= cfg_wdata_i;
        CFG_KEY3: key_q[63:0]    <= cfg_wdata_i;
        CFG_IVH:  iv_q[127:64]   <= cfg_wdata_i;
        CFG_IVL:  iv_q[63:0]     <= cfg_wdata_i;
        CFG_MODE: dec_q          <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Expansion starts the cycle after the write so it sees the new key; it also
  // runs once right after reset to expand the all-zero key.
  logic start_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) start_q <= 1'b1;
    else start_q <= key_wr;
  end

  acc_key_sched u_ks (
    .clk_i, .rst_ni, .start_i(start_q), .key_i(key_q),
    .rd_addr_i(rk_addr), .rd_row_o(rk), .status_o(ks)
  );

  acc_core u_core (
    .clk_i, .rst_ni, .ks_i(ks), .rk_i(rk), .rk_addr_o(rk_addr),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_block_i({s_axis_tdata[63:0], s_axis_tdata[127:64]}), .in_last_i(s_axis_tuser),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_block_o(res),
    .iv_i({iv_ld[1] ? cfg_wdata_i : iv_q[127:64], iv_ld[0] ? cfg_wdata_i : iv_q[63:0]}),
    .iv_load_i(iv_ld), .decrypt_i(dec_q)
  );

  assign m_axis_tdata = {res[63:0], res[127:64]};
endmodule

FILE: src/acc_checker.sv
// Port-level checker for the AES-256 CBC block, bound to the top level.
// Depends on acc_pkg and aes256_cbc_cipher_assert.svh.
`include "aes256_cbc_cipher_assert.svh"
module acc_checker import acc_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [127:0] m_axis_tdata
);
  `ACC_ASSERT_NXT(a_no_ready_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `ACC_ASSERT_NXT(a_no_out_right_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !m_axis_tvalid || $past(m_axis_tvalid))
  `ACC_ASSERT_NXT(a_out_holds, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind aes256_cbc_cipher acc_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata
);
